[hw/rtl/wfba_pkg.sv]
// Worst-fit block allocator: shared types and constants.
// Field widths, item kind codes and the sequencer state type.
// No dependencies.
package wfba_pkg;

  localparam int unsigned KIND_W  = 1;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned COUNT_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

  localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } wfba_state_e;

endpackage

[hw/rtl/wfba_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wfba_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/worst_fit_block_allocator_core.sv]
// Worst-fit block allocator, top level.
// Depends on wfba_pkg and wfba_ram.
//
// Usage:
//   Input words are taken on start_i while busy_o is low. A load word
//   (kind_i = load) writes size_i into block block_index_i and marks it free;
//   it completes in the cycle it is taken and gives no result, so busy_o
//   stays low. A request word scans blocks 0 .. N-1, N = min(block count,
//   MAX_BLOCKS), one RAM read per cycle, for the largest free block that
//   fits, lowest index on ties. While busy_o is high the core issues the N
//   reads, compares the last word read, then writes the used flag back and
//   registers the result. The result word appears on
//   done_o / granted_o / chosen_block_o / leftover_o for exactly one cycle,
//   the first cycle with busy_o low; a new word may be started in that cycle.
//   The receiver cannot stall. Throughput is set by the single RAM read port.
//   Block count is written on the cfg channel while idle (cfg_ready_o is
//   high whenever busy_o is low). Reset sets the block count to 16 and
//   returns to idle; block sizes and flags hold nothing until loaded.
module worst_fit_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wfba_pkg::COUNT_W-1:0]   cfg_block_count_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [wfba_pkg::KIND_W-1:0]    kind_i,
  input  logic [wfba_pkg::INDEX_W-1:0]   block_index_i,
  input  logic [wfba_pkg::SIZE_W-1:0]    size_i,
  output logic                           done_o,
  output logic                           granted_o,
  output logic [wfba_pkg::INDEX_W-1:0]   chosen_block_o,
  output logic [wfba_pkg::SIZE_W-1:0]    leftover_o
);

  import wfba_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned LIM_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CMP_W  = (LIM_W > COUNT_W) ? LIM_W : COUNT_W;
  localparam int unsigned IXC_W  = (LIM_W > INDEX_W) ? LIM_W : INDEX_W;
  localparam int unsigned WORD_W = SIZE_BITS + 1;

  wfba_state_e state_q, state_d;

  logic [COUNT_W-1:0]   count_q, count_d;
  logic [LIM_W-1:0]     ptr_q, ptr_d;
  logic [LIM_W-1:0]     limit_q, limit_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic [SIZE_BITS-1:0] amount_q, amount_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0] best_size_q, best_size_d;
  logic                 done_q, done_d;
  logic                 granted_q, granted_d;
  logic [INDEX_W-1:0]   chosen_q, chosen_d;
  logic [SIZE_W-1:0]    leftover_q, leftover_d;

  logic                 accept;
  logic                 issue;
  logic                 finish;
  logic                 hit;
  logic                 idx_ok;
  logic [CMP_W-1:0]     count_ext;
  logic [LIM_W-1:0]     active_limit;
  logic [SIZE_BITS-1:0] size_cut;
  logic [SIZE_BITS-1:0] diff;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;
  logic                 rd_used;
  logic [SIZE_BITS-1:0] rd_size;

  // RAM word: {used, size}
  wfba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_used  = ram_rdata[SIZE_BITS];
  assign rd_size  = ram_rdata[SIZE_BITS-1:0];
  assign size_cut = SIZE_BITS'(size_i);
  assign diff     = best_size_q - amount_q;

  assign count_ext    = CMP_W'(count_q);
  assign active_limit = (count_ext > CMP_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS)
                                                         : LIM_W'(count_ext);
  assign idx_ok       = IXC_W'(block_index_i) < IXC_W'(MAX_BLOCKS);

  assign accept = start_i && (state_q == ST_IDLE);
  assign issue  = (state_q == ST_SCAN) && (ptr_q < limit_q);
  assign finish = (state_q == ST_SCAN) && !issue && !rd_vld_q;
  assign hit    = rd_vld_q && !rd_used && (rd_size >= amount_q) &&
                  (!found_q || (rd_size > best_size_q));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    limit_d     = limit_q;
    rd_vld_d    = issue;
    rd_idx_d    = ptr_q[IDX_W-1:0];
    amount_d    = amount_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_size_d = best_size_q;
    done_d      = 1'b0;
    granted_d   = granted_q;
    chosen_d    = chosen_q;
    leftover_d  = leftover_q;
    ram_we      = 1'b0;
    ram_waddr   = IDX_W'(block_index_i);
    ram_wdata   = {1'b0, size_cut};

    if (cfg_valid_i && (state_q == ST_IDLE)) begin
      count_d = cfg_block_count_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_LOAD) begin
            // load marks the block free again
            ram_we = idx_ok;
          end else begin
            state_d  = ST_SCAN;
            ptr_d    = '0;
            limit_d  = active_limit;
            amount_d = size_cut;
            found_d  = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          ptr_d = ptr_q + LIM_W'(1);
        end
        if (hit) begin
          found_d     = 1'b1;
          best_idx_d  = rd_idx_q;
          best_size_d = rd_size;
        end
        if (finish) begin
          state_d    = ST_IDLE;
          done_d     = 1'b1;
          granted_d  = found_q;
          chosen_d   = found_q ? INDEX_W'(best_idx_q) : '0;
          leftover_d = found_q ? SIZE_W'(diff) : '0;
          ram_we     = found_q;
          ram_waddr  = best_idx_q;
          ram_wdata  = {1'b1, best_size_q};
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= COUNT_RESET;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
      granted_q  <= 1'b0;
      chosen_q   <= '0;
      leftover_q <= '0;
      ptr_q      <= '0;
      limit_q    <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_vld_q   <= rd_vld_d;
      found_q    <= found_d;
      done_q     <= done_d;
      granted_q  <= granted_d;
      chosen_q   <= chosen_d;
      leftover_q <= leftover_d;
      ptr_q      <= ptr_d;
      limit_q    <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    amount_q    <= amount_d;
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign cfg_ready_o    = (state_q == ST_IDLE);
  assign done_o         = done_q;
  assign granted_o      = granted_q;
  assign chosen_block_o = chosen_q;
  assign leftover_o     = leftover_q;

endmodule

[bench/worst_fit_block_allocator_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for worst_fit_block_allocator_core: directed and random load/request words.
// A scoreboard class predicts each grant; depends on wfba_pkg and the allocator RTL.
module worst_fit_block_allocator_core_tb;
  import wfba_pkg::*;

  localparam int NBLK    = 16;
  localparam int SETTLE  = NBLK + 4;   // cycles of margin after the last grant word

  class alloc_scoreboard;
    typedef struct packed {
      logic               granted;
      logic [INDEX_W-1:0] blk;
      logic [SIZE_W-1:0]  left;
    } grant_t;

    logic [SIZE_W-1:0]  sizes [NBLK];
    bit                 used  [NBLK];
    logic [COUNT_W-1:0] count;
    grant_t             grant_q [$];
    int                 errors;

    function new();
      count  = COUNT_RESET;
      errors = 0;
      foreach (sizes[i]) begin
        sizes[i] = '0;
        used[i]  = 1'b0;
      end
    endfunction

    function void set_count(logic [COUNT_W-1:0] c);
      count = c;
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    // Called for every accepted input word.
    function void note_word(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                            logic [SIZE_W-1:0] sz);
      int     lim;
      int     best;
      bit     found;
      grant_t g;
      if (kind == KIND_LOAD) begin
        sizes[idx] = sz;
        used[idx]  = 1'b0;
        return;
      end
      lim   = (count > NBLK) ? NBLK : int'(count);
      best  = 0;
      found = 1'b0;
      for (int j = 0; j < lim; j++) begin
        if (used[j] || sizes[j] < sz) continue;
        if (!found || sizes[j] > sizes[best]) begin
          best  = j;
          found = 1'b1;
        end
      end
      if (found) begin
        used[best] = 1'b1;
        g.granted  = 1'b1;
        g.blk      = INDEX_W'(best);
        g.left     = sizes[best] - sz;
      end else begin
        g = '0;
      end
      grant_q.push_back(g);
    endfunction

    function void check_result(logic granted, logic [INDEX_W-1:0] blk,
                               logic [SIZE_W-1:0] left);
      grant_t e;
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result word granted=%0d block=%0d leftover=%0d",
                 $time, granted, blk, left);
        errors++;
        return;
      end
      e = grant_q.pop_front();
      if (granted !== e.granted) begin
        $display("%0t: granted mismatch: expected %0d, actual %0d", $time, e.granted, granted);
        errors++;
      end
      if (blk !== e.blk) begin
        $display("%0t: chosen_block mismatch: expected %0d, actual %0d", $time, e.blk, blk);
        errors++;
      end
      if (left !== e.left) begin
        $display("%0t: leftover mismatch: expected %0d, actual %0d", $time, e.left, left);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [COUNT_W-1:0] cfg_block_count_i;
  logic               start_i;
  logic               busy_o;
  logic [KIND_W-1:0]  kind_i;
  logic [INDEX_W-1:0] block_index_i;
  logic [SIZE_W-1:0]  size_i;
  logic               done_o;
  logic               granted_o;
  logic [INDEX_W-1:0] chosen_block_o;
  logic [SIZE_W-1:0]  leftover_o;

  alloc_scoreboard sb = new();

  worst_fit_block_allocator_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_block_count_i (cfg_block_count_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .kind_i            (kind_i),
    .block_index_i     (block_index_i),
    .size_i            (size_i),
    .done_o            (done_o),
    .granted_o         (granted_o),
    .chosen_block_o    (chosen_block_o),
    .leftover_o        (leftover_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(granted_o, chosen_block_o, leftover_o);
  end

  // Drive one word and hold it until taken; start stays high afterwards.
  task automatic send_word(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                           logic [SIZE_W-1:0] sz);
    @(negedge clk_i);
    start_i       = 1'b1;
    kind_i        = kind;
    block_index_i = idx;
    size_i        = sz;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    sb.note_word(kind, idx, sz);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Wait until every grant word is back and the core is idle.
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy_o);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] c);
    drain();
    @(negedge clk_i);
    cfg_valid_i       = 1'b1;
    cfg_block_count_i = c;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_count(c);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_load_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    // few distinct values so that ties happen
    if (r < 45) return SIZE_W'($urandom_range(1, 4) * 16'h2000);
    return SIZE_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_request_size();
    int                r;
    int                j;
    int                slack;
    logic [SIZE_W-1:0] base;
    r    = $urandom_range(0, 99);
    j    = $urandom_range(0, NBLK - 1);
    base = sb.sizes[j];
    if (r < 40) begin
      slack = $urandom_range(0, (base < 400) ? int'(base) : 400);
      return base - SIZE_W'(slack);
    end
    if (r < 50) return base;
    if (r < 60) return '0;
    if (r < 65) return '1;
    return SIZE_W'($urandom_range(0, 65535));
  endfunction

  task automatic random_phase(int n, bit steady);
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] sz;
    for (int i = 0; i < n; i++) begin
      kind = ($urandom_range(0, 99) < 40) ? KIND_LOAD : KIND_REQUEST;
      sz   = (kind == KIND_LOAD) ? pick_load_size() : pick_request_size();
      send_word(kind, INDEX_W'($urandom_range(0, NBLK - 1)), sz);
      if (!steady) idle_cycles(pick_gap());
      if ($urandom_range(0, 99) < 2) drain();
    end
  endtask

  initial begin
    #10_000_000;
    $display("worst_fit_block_allocator_core verification failed");
    $finish;
  end

  initial begin
    logic [COUNT_W-1:0] counts [8];
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_block_count_i = '0;
    start_i           = 1'b0;
    kind_i            = KIND_LOAD;
    block_index_i     = '0;
    size_i            = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Load every block first so no search ever touches an unwritten size.
    // Blocks 0 and 15 tie at the maximum, block 3 is empty.
    for (int i = 0; i < NBLK; i++) begin
      send_word(KIND_LOAD, INDEX_W'(i),
                (i == 0 || i == 15) ? 16'hFFFF : (i == 3) ? 16'h0000 : 16'(i * 16'h0999));
    end
    send_word(KIND_REQUEST, 4'hF, 16'hFFFF);  // tie, lowest index wins
    send_word(KIND_REQUEST, 4'h0, 16'hFFFF);  // next of the tie
    send_word(KIND_REQUEST, 4'h5, 16'hFFFF);  // nothing fits
    send_word(KIND_LOAD,    4'h0, 16'hFFFF);  // reload a used block: free again
    send_word(KIND_REQUEST, 4'hA, 16'hFFFF);
    send_word(KIND_REQUEST, 4'h0, 16'h0000);  // zero request takes the largest free
    send_word(KIND_REQUEST, 4'h3, 16'h8000);
    idle_cycles(1);

    counts = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16, 5'd12, 5'd0};
    counts[7] = COUNT_W'($urandom_range(0, 31));
    foreach (counts[p]) begin
      write_count(counts[p]);
      random_phase(66, (p % 3) == 1);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("worst_fit_block_allocator_core verification clean");
    end else begin
      $display("worst_fit_block_allocator_core verification failed");
    end
    $finish;
  end

endmodule
